[src/aabb_contact_impulse_unit_macros.svh]
// Assertion helpers for the checker of this block
`ifndef AABB_CONTACT_IMPULSE_UNIT_MACROS_SVH
`define AABB_CONTACT_IMPULSE_UNIT_MACROS_SVH

// Checked only outside reset
`define ACI_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define ACI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/aci_pkg.sv]
package aci_pkg;

	localparam int COORD_BITS_DEF = 16;

	// axis codes
	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	localparam logic [8:0] ONE_Q8 = 9'd256;

	// per-pair control flags travelling from classification to output
	typedef struct packed {
		logic       hit;
		logic [1:0] axis;
		logic       nneg;   // normal points negative
		logic       fault;  // inverse mass sum is zero
		logic       sta;
		logic       stb;
		logic       imp;    // impulse to be applied
		logic       rneg;   // relative velocity below zero
	} ctl_t;

endpackage

[src/aabb_contact_impulse_unit.sv]
// Box-pair contact and impulse unit. One body pair is taken per transaction: two
// axis-aligned boxes, velocities, inverse masses, restitutions and static flags.
// The unit reports whether the boxes overlap (touching counts), the axis of least
// overlap (x, then y, then z on ties), the normal sign, the depth, the positional
// correction of each body and each body's new velocity on that axis, with every
// result saturated to 16 bits. A new pair can be taken on every clock cycle while
// in_stall is low. The back end holds four pipelined dividers, which retire one
// quotient bit per stage. The front end checks and classifies the pair and forms
// the products over three stages, then hands them to a two-entry queue, so an
// output stall does not stop the input until that queue is full. Both channels
// use valid/stall; a transaction moves when valid is high and stall is low.
module aabb_contact_impulse_unit #(
	parameter int COORD_BITS = aci_pkg::COORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [47:0]        a_min,
	input  logic [47:0]        a_max,
	input  logic [47:0]        b_min,
	input  logic [47:0]        b_max,
	input  logic [47:0]        a_velocity,
	input  logic [47:0]        b_velocity,
	input  logic [15:0]        a_inv_mass,
	input  logic [15:0]        b_inv_mass,
	input  logic [8:0]         a_restitution,
	input  logic [8:0]         b_restitution,
	input  logic [1:0]         static_flags,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               hit,
	output logic [1:0]         axis,
	output logic               normal_negative,
	output logic [15:0]        depth,
	output logic signed [15:0] a_shift,
	output logic signed [15:0] b_shift,
	output logic signed [15:0] a_axis_velocity,
	output logic signed [15:0] b_axis_velocity,
	output logic               mass_fault
);
	import aci_pkg::*;

	localparam int C  = COORD_BITS;
	// queue entry: control flags, depth, two velocities, mass sum, four products
	localparam int QE = $bits(ctl_t) + 3*C + 17 + 2*(C+16) + 2*(C+25);

	logic          q_full, q_nonempty, push, pop;
	logic [QE-1:0] q_wdata, q_rdata;

	ctl_t          f_ctl, h_ctl;
	logic [C-1:0]  f_depth, f_va, f_vb, h_depth, h_va, h_vb;
	logic [16:0]   f_sum, h_sum;
	logic [C+15:0] f_pa, f_pb, h_pa, h_pb;
	logic [C+24:0] f_ia, f_ib, h_ia, h_ib;

	// front: overlap test, axis choice, products
	aci_front #(.C(C)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.a_min(a_min), .a_max(a_max), .b_min(b_min), .b_max(b_max),
		.a_velocity(a_velocity), .b_velocity(b_velocity),
		.a_inv_mass(a_inv_mass), .b_inv_mass(b_inv_mass),
		.a_restitution(a_restitution), .b_restitution(b_restitution),
		.static_flags(static_flags),
		.q_full(q_full), .push(push),
		.f_ctl(f_ctl), .f_depth(f_depth), .f_va(f_va), .f_vb(f_vb), .f_sum(f_sum),
		.f_pa(f_pa), .f_pb(f_pb), .f_ia(f_ia), .f_ib(f_ib)
	);

	assign q_wdata = {f_ctl, f_depth, f_va, f_vb, f_sum, f_pa, f_pb, f_ia, f_ib};

	aci_queue #(.W(QE)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .wdata(q_wdata),
		.pop(pop), .full(q_full), .nonempty(q_nonempty), .rdata(q_rdata)
	);

	assign {h_ctl, h_depth, h_va, h_vb, h_sum, h_pa, h_pb, h_ia, h_ib} = q_rdata;

	// back: rounded divisions, sign and static gating, saturation, output register
	aci_back #(.C(C)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_nonempty(q_nonempty), .pop(pop),
		.h_ctl(h_ctl), .h_depth(h_depth), .h_va(h_va), .h_vb(h_vb), .h_sum(h_sum),
		.h_pa(h_pa), .h_pb(h_pb), .h_ia(h_ia), .h_ib(h_ib),
		.out_valid(out_valid), .out_stall(out_stall),
		.hit(hit), .axis(axis), .normal_negative(normal_negative), .depth(depth),
		.a_shift(a_shift), .b_shift(b_shift),
		.a_axis_velocity(a_axis_velocity), .b_axis_velocity(b_axis_velocity),
		.mass_fault(mass_fault)
	);

endmodule

[src/aci_div.sv]
module aci_div #(
	parameter int NW = 43,
	parameter int QW = 19,
	parameter int DW = 26
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo
);
	// restoring division, one quotient bit per stage; quotient known to fit QW bits
	logic [DW-1:0] rem_s [QW+1];
	logic [QW-1:0] lo_s  [QW+1];
	logic [DW-1:0] den_s [QW+1];

	logic [DW:0]   t_c    [QW];
	logic          ge_c   [QW];
	logic [DW-1:0] nrem_c [QW];
	logic [DW:0]   dif_c  [QW];

	always_comb begin
		for (int i = 0; i < QW; i++) begin
			t_c[i]    = {rem_s[i], lo_s[i][QW-1]};
			ge_c[i]   = t_c[i] >= {1'b0, den_s[i]};
			dif_c[i]  = t_c[i] - {1'b0, den_s[i]};
			nrem_c[i] = ge_c[i] ? dif_c[i][DW-1:0] : t_c[i][DW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= DW'(num[NW-1:QW]);
			lo_s[0]  <= num[QW-1:0];
			den_s[0] <= den;
			for (int i = 0; i < QW; i++) begin
				rem_s[i+1] <= nrem_c[i];
				lo_s[i+1]  <= {lo_s[i][QW-2:0], ge_c[i]};
				den_s[i+1] <= den_s[i];
			end
		end
	end

	assign quo = lo_s[QW];

endmodule

[src/aci_front.sv]
module aci_front #(
	parameter int C = aci_pkg::COORD_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [47:0]       a_min,
	input  logic [47:0]       a_max,
	input  logic [47:0]       b_min,
	input  logic [47:0]       b_max,
	input  logic [47:0]       a_velocity,
	input  logic [47:0]       b_velocity,
	input  logic [15:0]       a_inv_mass,
	input  logic [15:0]       b_inv_mass,
	input  logic [8:0]        a_restitution,
	input  logic [8:0]        b_restitution,
	input  logic [1:0]        static_flags,
	input  logic              q_full,
	output logic              push,
	output aci_pkg::ctl_t     f_ctl,
	output logic [C-1:0]      f_depth,
	output logic [C-1:0]      f_va,
	output logic [C-1:0]      f_vb,
	output logic [16:0]       f_sum,
	output logic [C+15:0]     f_pa,
	output logic [C+15:0]     f_pb,
	output logic [C+24:0]     f_ia,
	output logic [C+24:0]     f_ib
);
	import aci_pkg::*;

	logic [3*C-1:0] amn_w, amx_w, bmn_w, bmx_w, vla_w, vlb_w;
	logic signed [C-1:0] amn [3];
	logic signed [C-1:0] amx [3];
	logic signed [C-1:0] bmn [3];
	logic signed [C-1:0] bmx [3];
	logic signed [C-1:0] vla [3];
	logic signed [C-1:0] vlb [3];
	logic signed [C:0]   o1 [3];
	logic signed [C:0]   o2 [3];
	logic signed [C:0]   ov [3];
	logic signed [C+1:0] cd [3];
	logic                hit_c, nneg_c, fault_c, imp_c;
	logic [1:0]          ax_c;
	logic [C-1:0]        depth_c;
	logic signed [C-1:0] va_c, vb_c;
	logic signed [C:0]   r_c;
	logic [16:0]         sum_c;
	logic [8:0]          ea_c, eb_c, e_c;
	logic [9:0]          k_c;
	ctl_t                ctl_c;

	logic                adv;
	logic                v_s1, v_s2, v_s3;
	ctl_t                ctl_s1, ctl_s2, ctl_s3;
	logic [C-1:0]        depth_s1, depth_s2, depth_s3;
	logic [C-1:0]        va_s1, va_s2, va_s3;
	logic [C-1:0]        vb_s1, vb_s2, vb_s3;
	logic signed [C:0]   r_s1;
	logic [16:0]         sum_s1, sum_s2, sum_s3;
	logic [9:0]          k_s1;
	logic [15:0]         ima_s1, ima_s2, imb_s1, imb_s2;
	logic [C+15:0]       pa_s2, pa_s3, pb_s2, pb_s3;
	logic [C+10:0]       rk_s2;
	logic [C+24:0]       ia_s3, ib_s3;
	logic [C:0]          rmag;
	logic [C+26:0]       ia_full, ib_full;

	assign amn_w = (3*C)'(a_min);
	assign amx_w = (3*C)'(a_max);
	assign bmn_w = (3*C)'(b_min);
	assign bmx_w = (3*C)'(b_max);
	assign vla_w = (3*C)'(a_velocity);
	assign vlb_w = (3*C)'(b_velocity);

	always_comb begin
		hit_c = 1'b1;
		for (int k = 0; k < 3; k++) begin
			amn[k] = $signed(amn_w[k*C +: C]);
			amx[k] = $signed(amx_w[k*C +: C]);
			bmn[k] = $signed(bmn_w[k*C +: C]);
			bmx[k] = $signed(bmx_w[k*C +: C]);
			vla[k] = $signed(vla_w[k*C +: C]);
			vlb[k] = $signed(vlb_w[k*C +: C]);
			if (amx[k] < bmn[k] || amn[k] > bmx[k]) begin
				hit_c = 1'b0;
			end
			o1[k] = (C+1)'(bmx[k]) - (C+1)'(amn[k]);
			o2[k] = (C+1)'(amx[k]) - (C+1)'(bmn[k]);
			ov[k] = (o1[k] < o2[k]) ? o1[k] : o2[k];
			cd[k] = ((C+2)'(amn[k]) + (C+2)'(amx[k])) - ((C+2)'(bmn[k]) + (C+2)'(bmx[k]));
		end

		priority if (ov[0] <= ov[1] && ov[0] <= ov[2]) begin
			ax_c = AXIS_X;
		end else if (ov[1] <= ov[0] && ov[1] <= ov[2]) begin
			ax_c = AXIS_Y;
		end else begin
			ax_c = AXIS_Z;
		end

		unique case (ax_c)
			AXIS_X: begin
				depth_c = ov[0][C-1:0];
				nneg_c  = !(cd[0] > 0);
				va_c    = vla[0];
				vb_c    = vlb[0];
			end
			AXIS_Y: begin
				depth_c = ov[1][C-1:0];
				nneg_c  = !(cd[1] > 0);
				va_c    = vla[1];
				vb_c    = vlb[1];
			end
			AXIS_Z: begin
				depth_c = ov[2][C-1:0];
				nneg_c  = !(cd[2] > 0);
				va_c    = vla[2];
				vb_c    = vlb[2];
			end
			default: begin
				depth_c = '0;
				nneg_c  = 1'b0;
				va_c    = '0;
				vb_c    = '0;
			end
		endcase

		r_c     = (C+1)'(va_c) - (C+1)'(vb_c);
		sum_c   = {1'b0, a_inv_mass} + {1'b0, b_inv_mass};
		fault_c = (sum_c == 17'd0);
		imp_c   = !fault_c && (nneg_c ? (r_c >= 0) : (r_c <= 0));
		ea_c    = (a_restitution > ONE_Q8) ? ONE_Q8 : a_restitution;
		eb_c    = (b_restitution > ONE_Q8) ? ONE_Q8 : b_restitution;
		e_c     = (ea_c < eb_c) ? ea_c : eb_c;
		k_c     = {1'b0, ONE_Q8} + {1'b0, e_c};

		ctl_c.hit   = hit_c;
		ctl_c.axis  = ax_c;
		ctl_c.nneg  = nneg_c;
		ctl_c.fault = fault_c;
		ctl_c.sta   = static_flags[0];
		ctl_c.stb   = static_flags[1];
		ctl_c.imp   = imp_c;
		ctl_c.rneg  = r_c < 0;
	end

	// whole front moves together; it holds only when its last stage cannot enter the queue
	assign adv      = !v_s3 || !q_full;
	assign in_stall = !adv;
	assign push     = v_s3 && !q_full;

	assign rmag    = r_s1[C] ? (C+1)'(-r_s1) : (C+1)'(r_s1);
	assign ia_full = (C+27)'(rk_s2) * (C+27)'(ima_s2);
	assign ib_full = (C+27)'(rk_s2) * (C+27)'(imb_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1   <= ctl_c;
			depth_s1 <= depth_c;
			va_s1    <= va_c;
			vb_s1    <= vb_c;
			r_s1     <= r_c;
			sum_s1   <= sum_c;
			k_s1     <= k_c;
			ima_s1   <= a_inv_mass;
			imb_s1   <= b_inv_mass;

			ctl_s2   <= ctl_s1;
			depth_s2 <= depth_s1;
			va_s2    <= va_s1;
			vb_s2    <= vb_s1;
			sum_s2   <= sum_s1;
			ima_s2   <= ima_s1;
			imb_s2   <= imb_s1;
			pa_s2    <= (C+16)'(depth_s1) * (C+16)'(ima_s1);
			pb_s2    <= (C+16)'(depth_s1) * (C+16)'(imb_s1);
			rk_s2    <= (C+11)'(rmag) * (C+11)'(k_s1);

			ctl_s3   <= ctl_s2;
			depth_s3 <= depth_s2;
			va_s3    <= va_s2;
			vb_s3    <= vb_s2;
			sum_s3   <= sum_s2;
			pa_s3    <= pa_s2;
			pb_s3    <= pb_s2;
			// |r|*(1+e)*inv_mass stays below 2^(C+25)
			ia_s3    <= ia_full[C+24:0];
			ib_s3    <= ib_full[C+24:0];
		end
	end

	assign f_ctl   = ctl_s3;
	assign f_depth = depth_s3;
	assign f_va    = va_s3;
	assign f_vb    = vb_s3;
	assign f_sum   = sum_s3;
	assign f_pa    = pa_s3;
	assign f_pb    = pb_s3;
	assign f_ia    = ia_s3;
	assign f_ib    = ib_s3;

endmodule

[src/aci_queue.sv]
module aci_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic         full,
	output logic         nonempty,
	output logic [W-1:0] rdata
);
	logic [W-1:0] mem_q [2];
	logic         wp_q, rp_q;
	logic [1:0]   cnt_q;

	assign full     = cnt_q == 2'd2;
	assign nonempty = cnt_q != 2'd0;
	assign rdata    = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

endmodule

[src/aci_back.sv]
module aci_back #(
	parameter int C = aci_pkg::COORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_nonempty,
	output logic               pop,
	input  aci_pkg::ctl_t      h_ctl,
	input  logic [C-1:0]       h_depth,
	input  logic [C-1:0]       h_va,
	input  logic [C-1:0]       h_vb,
	input  logic [16:0]        h_sum,
	input  logic [C+15:0]      h_pa,
	input  logic [C+15:0]      h_pb,
	input  logic [C+24:0]      h_ia,
	input  logic [C+24:0]      h_ib,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               hit,
	output logic [1:0]         axis,
	output logic               normal_negative,
	output logic [15:0]        depth,
	output logic signed [15:0] a_shift,
	output logic signed [15:0] b_shift,
	output logic signed [15:0] a_axis_velocity,
	output logic signed [15:0] b_axis_velocity,
	output logic               mass_fault
);
	import aci_pkg::*;

	localparam int NW = C + 27;
	localparam int QW = C + 3;
	localparam int DW = 26;
	localparam int QS = C + 4;
	localparam int QX = (QS > 17) ? QS : 17;

	logic          adv;
	logic [NW-1:0] npa, npb, nia, nib;
	logic [DW-1:0] den_s, den_i;
	logic [QW-1:0] qa, qb, qia, qib;

	logic                v_s   [QW+1];
	ctl_t                ctl_s [QW+1];
	logic [C-1:0]        dep_s [QW+1];
	logic [C-1:0]        va_s  [QW+1];
	logic [C-1:0]        vb_s  [QW+1];

	ctl_t                cf;
	logic signed [QS-1:0] qa_x, qb_x, qia_x, qib_x, va_x, vb_x;
	logic signed [QS-1:0] sa_c, sb_c, van_c, vbn_c;
	logic [C+15:0]       dep_x;
	logic                out_valid_q;

	function automatic logic [15:0] sat16(input logic signed [QS-1:0] v);
		logic signed [QX-1:0] w;
		w = QX'(v);
		if (w > $signed(QX'(32767))) begin
			return 16'h7FFF;
		end else if (w < -$signed(QX'(32768))) begin
			return 16'h8000;
		end
		return w[15:0];
	endfunction

	assign adv = !out_valid_q || !out_stall;
	assign pop = q_nonempty && adv;

	// rounded quotients: (2*num + den) / (2*den)
	assign npa   = NW'({h_pa, 1'b0}) + NW'(h_sum);
	assign npb   = NW'({h_pb, 1'b0}) + NW'(h_sum);
	assign den_s = DW'({h_sum, 1'b0});
	assign nia   = NW'({h_ia, 1'b0}) + NW'({h_sum, 8'b0});
	assign nib   = NW'({h_ib, 1'b0}) + NW'({h_sum, 8'b0});
	assign den_i = DW'({h_sum, 9'b0});

	aci_div #(.NW(NW), .QW(QW), .DW(DW)) u_div_sa (
		.clk(clk), .en(adv), .num(npa), .den(den_s), .quo(qa)
	);
	aci_div #(.NW(NW), .QW(QW), .DW(DW)) u_div_sb (
		.clk(clk), .en(adv), .num(npb), .den(den_s), .quo(qb)
	);
	aci_div #(.NW(NW), .QW(QW), .DW(DW)) u_div_ia (
		.clk(clk), .en(adv), .num(nia), .den(den_i), .quo(qia)
	);
	aci_div #(.NW(NW), .QW(QW), .DW(DW)) u_div_ib (
		.clk(clk), .en(adv), .num(nib), .den(den_i), .quo(qib)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= QW; i++) begin
				v_s[i] <= 1'b0;
			end
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s[0] <= pop;
			for (int i = 0; i < QW; i++) begin
				v_s[i+1] <= v_s[i];
			end
			out_valid_q <= v_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s[0] <= h_ctl;
			dep_s[0] <= h_depth;
			va_s[0]  <= h_va;
			vb_s[0]  <= h_vb;
			for (int i = 0; i < QW; i++) begin
				ctl_s[i+1] <= ctl_s[i];
				dep_s[i+1] <= dep_s[i];
				va_s[i+1]  <= va_s[i];
				vb_s[i+1]  <= vb_s[i];
			end
		end
	end

	always_comb begin
		cf    = ctl_s[QW];
		qa_x  = $signed({1'b0, qa});
		qb_x  = $signed({1'b0, qb});
		qia_x = $signed({1'b0, qia});
		qib_x = $signed({1'b0, qib});
		va_x  = QS'($signed(va_s[QW]));
		vb_x  = QS'($signed(vb_s[QW]));
		dep_x = (C+16)'(dep_s[QW]);

		sa_c  = '0;
		sb_c  = '0;
		van_c = va_x;
		vbn_c = vb_x;
		if (!cf.fault && !cf.sta) begin
			sa_c = cf.nneg ? -qa_x : qa_x;
		end
		if (!cf.fault && !cf.stb) begin
			sb_c = cf.nneg ? qb_x : -qb_x;
		end
		if (cf.imp && !cf.sta) begin
			van_c = cf.rneg ? (va_x + qia_x) : (va_x - qia_x);
		end
		if (cf.imp && !cf.stb) begin
			vbn_c = cf.rneg ? (vb_x - qib_x) : (vb_x + qib_x);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (cf.hit) begin
				hit             <= 1'b1;
				axis            <= cf.axis;
				normal_negative <= cf.nneg;
				depth           <= (dep_x > (C+16)'(16'hFFFF)) ? 16'hFFFF : dep_x[15:0];
				a_shift         <= sat16(sa_c);
				b_shift         <= sat16(sb_c);
				a_axis_velocity <= sat16(van_c);
				b_axis_velocity <= sat16(vbn_c);
				mass_fault      <= cf.fault;
			end else begin
				hit             <= 1'b0;
				axis            <= AXIS_X;
				normal_negative <= 1'b0;
				depth           <= '0;
				a_shift         <= '0;
				b_shift         <= '0;
				a_axis_velocity <= '0;
				b_axis_velocity <= '0;
				mass_fault      <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

[src/aci_checker.sv]
`include "aabb_contact_impulse_unit_macros.svh"

module aci_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        hit,
	input logic [1:0]  axis,
	input logic [15:0] depth,
	input logic [15:0] a_shift,
	input logic [15:0] b_shift,
	input logic        mass_fault
);
	import aci_pkg::*;

	`ACI_ASSERT_ALWAYS(a_rst_idle, clk, !arst_n |-> !out_valid, "output valid during reset")
	`ACI_ASSERT(a_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(depth) && $stable(a_shift), "stalled result changed")
	`ACI_ASSERT(a_axis, clk, arst_n, out_valid |-> axis == AXIS_X || axis == AXIS_Y || axis == AXIS_Z, "bad axis code")
	`ACI_ASSERT(a_miss, clk, arst_n, out_valid && !hit |-> depth == 16'd0 && axis == AXIS_X && !mass_fault, "miss with non-zero result")
	`ACI_ASSERT(a_fault, clk, arst_n, out_valid && mass_fault |-> a_shift == 16'd0 && b_shift == 16'd0, "shift with zero mass sum")

endmodule

bind aabb_contact_impulse_unit aci_checker u_aci_checker (.*);

[sim/aabb_contact_impulse_unit_tb.sv]
`timescale 1ns / 1ps

// Box-pair contact unit bench.
// Body pairs go in through send_pair. Each accepted transaction is scored at once by
// predict_contact, and the predicted result is queued in contact_q. The output monitor
// compares each accepted result, field by field, with the head of that queue.
module aabb_contact_impulse_unit_tb;
	import aci_pkg::*;

	localparam int  LIMIT_CYCLES = 400000;
	localparam int  DRAIN_CYCLES = 60;      // margin after the last result
	localparam int  HOLD_CYCLES  = 300;
	localparam bit [1:0] STATIC_A = 2'b01;
	localparam bit [1:0] STATIC_B = 2'b10;

	// one body pair, as presented on the input ports
	typedef struct {
		bit [47:0] amin, amax, bmin, bmax, va, vb;
		bit [15:0] ima, imb;
		bit [8:0]  ea, eb;
		bit [1:0]  st;
	} pair_t;

	// one contact result, as seen on the output ports
	typedef struct {
		bit        hit;
		bit [1:0]  axis;
		bit        nneg;
		bit [15:0] depth;
		bit [15:0] sa, sb, va, vb;
		bit        fault;
	} contact_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [47:0] a_min = '0, a_max = '0, b_min = '0, b_max = '0;
	logic [47:0] a_velocity = '0, b_velocity = '0;
	logic [15:0] a_inv_mass = '0, b_inv_mass = '0;
	logic [8:0]  a_restitution = '0, b_restitution = '0;
	logic [1:0]  static_flags = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic hit, normal_negative, mass_fault;
	logic [1:0] axis;
	logic [15:0] depth;
	logic signed [15:0] a_shift, b_shift, a_axis_velocity, b_axis_velocity;

	contact_t contact_q[$];
	int  n_sent = 0, n_checked = 0, n_hits = 0, n_faults = 0, n_errors = 0;
	int  cycle_cnt = 0;
	bit  idle_on = 1'b1;      // random gaps and stalls enabled
	int  hold_count = 0;      // bumped by a test to request a long output hold-off
	int  hold_seen = 0;
	int  hold_left = 0;
	int  stall_left = 0;

	aabb_contact_impulse_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.a_min(a_min), .a_max(a_max), .b_min(b_min), .b_max(b_max),
		.a_velocity(a_velocity), .b_velocity(b_velocity),
		.a_inv_mass(a_inv_mass), .b_inv_mass(b_inv_mass),
		.a_restitution(a_restitution), .b_restitution(b_restitution),
		.static_flags(static_flags),
		.out_valid(out_valid), .out_stall(out_stall),
		.hit(hit), .axis(axis), .normal_negative(normal_negative), .depth(depth),
		.a_shift(a_shift), .b_shift(b_shift),
		.a_axis_velocity(a_axis_velocity), .b_axis_velocity(b_axis_velocity),
		.mass_fault(mass_fault)
	);

	always #4 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
				contact_q.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// ---------------------------------------------------------------- predictor

	// signed Q8.8 lane k of a packed corner or velocity
	function automatic longint lane(bit [47:0] w, int k);
		logic signed [15:0] v;
		v = w[16*k +: 16];
		return longint'(v);
	endfunction

	// divide, rounding to nearest with ties away from zero
	function automatic longint div_round(longint num, longint den);
		longint mag, q;
		mag = (num < 0) ? -num : num;
		q = (mag * 2 + den) / (den * 2);
		return (num < 0) ? -q : q;
	endfunction

	function automatic bit [15:0] clamp16(longint x);
		if (x > 32767)
			x = 32767;
		if (x < -32768)
			x = -32768;
		return x[15:0];
	endfunction

	function automatic contact_t predict_contact(pair_t p);
		contact_t r;
		longint amn[3], amx[3], bmn[3], bmx[3], ov[3], cd[3];
		longint dep, n, rel, va, vb, sa, sb, sum, ea, eb, e;
		bit sta, stb, fault;
		bit [1:0] ax;
		r = '{default: 0};
		sa = 0;
		sb = 0;
		for (int k = 0; k < 3; k++) begin
			amn[k] = lane(p.amin, k);
			amx[k] = lane(p.amax, k);
			bmn[k] = lane(p.bmin, k);
			bmx[k] = lane(p.bmax, k);
			// apart on any axis: the whole result is zero
			if (amx[k] < bmn[k] || amn[k] > bmx[k])
				return r;
		end
		for (int k = 0; k < 3; k++) begin
			ov[k] = (bmx[k] - amn[k] < amx[k] - bmn[k]) ? bmx[k] - amn[k] : amx[k] - bmn[k];
			cd[k] = (amn[k] + amx[k]) - (bmn[k] + bmx[k]);
		end
		// least overlap, x wins ties over y, y over z
		if (ov[0] <= ov[1] && ov[0] <= ov[2])
			ax = AXIS_X;
		else if (ov[1] <= ov[0] && ov[1] <= ov[2])
			ax = AXIS_Y;
		else
			ax = AXIS_Z;
		dep = ov[ax];
		n = (cd[ax] > 0) ? 1 : -1;
		va = lane(p.va, int'(ax));
		vb = lane(p.vb, int'(ax));
		sta = (p.st & STATIC_A) != 0;
		stb = (p.st & STATIC_B) != 0;
		sum = longint'(p.ima) + longint'(p.imb);
		fault = (sum == 0);
		if (!fault && !(sta && stb)) begin
			if (!sta)
				sa = n * div_round(dep * p.ima, sum);
			if (!stb)
				sb = -n * div_round(dep * p.imb, sum);
			rel = va - vb;
			// impulse only when approaching or at rest relative to each other
			if (n * rel <= 0) begin
				ea = (p.ea > ONE_Q8) ? ONE_Q8 : p.ea;
				eb = (p.eb > ONE_Q8) ? ONE_Q8 : p.eb;
				e = (ea < eb) ? ea : eb;
				if (!sta)
					va += div_round(-rel * (256 + e) * p.ima, sum * 256);
				if (!stb)
					vb += div_round(rel * (256 + e) * p.imb, sum * 256);
			end
		end
		r.hit = 1'b1;
		r.axis = ax;
		r.nneg = (n < 0);
		r.depth = (dep > 65535) ? 16'hFFFF : dep[15:0];
		r.sa = clamp16(sa);
		r.sb = clamp16(sb);
		r.va = clamp16(va);
		r.vb = clamp16(vb);
		r.fault = fault;
		return r;
	endfunction

	// ---------------------------------------------------------------- input side

	// mostly no gap, now and then a short one, rarely a long one
	function automatic int pick_gap();
		int d;
		if (!idle_on)
			return 0;
		d = $urandom_range(0, 19);
		if (d < 13)
			return 0;
		if (d < 18)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offer one pair and hold it until accepted. Valid stays high on return so
	// a back-to-back transaction does not drop it for a cycle.
	task automatic send_pair(pair_t p);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		a_min <= p.amin;
		a_max <= p.amax;
		b_min <= p.bmin;
		b_max <= p.bmax;
		a_velocity <= p.va;
		b_velocity <= p.vb;
		a_inv_mass <= p.ima;
		b_inv_mass <= p.imb;
		a_restitution <= p.ea;
		b_restitution <= p.eb;
		static_flags <= p.st;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		contact_q.insert(contact_q.size(), predict_contact(p));
		n_sent++;
	endtask

	function automatic bit [47:0] xyz(int x, int y, int z);
		return {z[15:0], y[15:0], x[15:0]};
	endfunction

	function automatic pair_t mk(bit [47:0] amn, bit [47:0] amx, bit [47:0] bmn,
			bit [47:0] bmx, bit [47:0] va, bit [47:0] vb, int ima, int imb,
			int ea, int eb, bit [1:0] st);
		pair_t p;
		p.amin = amn; p.amax = amx; p.bmin = bmn; p.bmax = bmx;
		p.va = va; p.vb = vb;
		p.ima = 16'(ima); p.imb = 16'(imb); p.ea = 9'(ea); p.eb = 9'(eb); p.st = st;
		return p;
	endfunction

	// Random pair. Most are built from small boxes placed close together, so that they
	// often overlap; the rest are raw bit patterns (extremes, inverted boxes, misses).
	function automatic pair_t rand_pair();
		pair_t p;
		int lo, sz, bo, bs;
		bit [15:0] m;
		if ($urandom_range(0, 9) < 3) begin
			p.amin = 48'({$urandom, $urandom}); p.amax = 48'({$urandom, $urandom});
			p.bmin = 48'({$urandom, $urandom}); p.bmax = 48'({$urandom, $urandom});
		end else begin
			for (int k = 0; k < 3; k++) begin
				lo = $urandom_range(0, 1200) - 600;
				sz = $urandom_range(0, 512);
				bo = lo + $urandom_range(0, sz + 200) - 100;
				bs = $urandom_range(0, 512);
				p.amin[16*k +: 16] = lo[15:0];
				p.amax[16*k +: 16] = 16'(lo + sz);
				p.bmin[16*k +: 16] = bo[15:0];
				p.bmax[16*k +: 16] = 16'(bo + bs);
			end
		end
		p.va = 48'({$urandom, $urandom});
		p.vb = 48'({$urandom, $urandom});
		if ($urandom_range(0, 1)) begin
			// modest velocities so impulses do not all saturate
			for (int k = 0; k < 3; k++) begin
				m = 16'($urandom_range(0, 2048) - 1024);
				p.va[16*k +: 16] = m;
				m = 16'($urandom_range(0, 2048) - 1024);
				p.vb[16*k +: 16] = m;
			end
		end
		case ($urandom_range(0, 5))
			0:       begin p.ima = '0; p.imb = $urandom_range(0, 1) ? '0 : 16'($urandom); end
			1:       begin p.ima = 16'($urandom); p.imb = 16'($urandom); end
			default: begin
				p.ima = 16'($urandom_range(0, 512));
				p.imb = 16'($urandom_range(0, 512));
			end
		endcase
		p.ea = 9'(($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 256));
		p.eb = 9'(($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 256));
		p.st = 2'(($urandom_range(0, 3) == 0) ? $urandom : 0);
		return p;
	endfunction

	// ---------------------------------------------------------------- output side

	// Output stall: random bursts, or a long counted hold-off when a test asks.
	always @(posedge clk) begin
		if (hold_seen != hold_count) begin
			hold_seen <= hold_count;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 9) < 2) begin
			stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
				: $urandom_range(0, 2);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic note_diff(string fld, longint exp_v, longint act_v);
		n_errors++;
		if (n_errors <= 10)
			$display("mismatch on result %0d, %s: expected %0d (0x%0h), got %0d (0x%0h)",
				n_checked, fld, exp_v, exp_v, act_v, act_v);
	endtask

	// score every result transaction against the oldest prediction
	always @(posedge clk) begin
		contact_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (contact_q.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("unexpected result transaction, nothing predicted");
			end else begin
				e = contact_q.pop_front();
				if (e.hit !== hit) note_diff("hit", e.hit, hit);
				if (e.axis !== axis) note_diff("axis", e.axis, axis);
				if (e.nneg !== normal_negative)
					note_diff("normal_negative", e.nneg, normal_negative);
				if (e.depth !== depth) note_diff("depth", e.depth, depth);
				if (e.sa !== a_shift) note_diff("a_shift", $signed(e.sa), a_shift);
				if (e.sb !== b_shift) note_diff("b_shift", $signed(e.sb), b_shift);
				if (e.va !== a_axis_velocity)
					note_diff("a_axis_velocity", $signed(e.va), a_axis_velocity);
				if (e.vb !== b_axis_velocity)
					note_diff("b_axis_velocity", $signed(e.vb), b_axis_velocity);
				if (e.fault !== mass_fault) note_diff("mass_fault", e.fault, mass_fault);
				n_hits += e.hit;
				n_faults += e.fault;
				n_checked++;
			end
		end
	end

	// ---------------------------------------------------------------- tests

	// Hand-built pairs: misses, touching, axis ties, static and mass corners,
	// separating pairs, restitution clamp, inverted boxes and saturation.
	task automatic test_directed();
		bit [47:0] z0, u1, v0;
		z0 = xyz(0, 0, 0);
		u1 = xyz(256, 256, 256);
		v0 = xyz(0, 0, 0);
		// clear miss on x
		send_pair(mk(z0, u1, xyz(512, 0, 0), xyz(768, 256, 256), v0, v0,
			256, 256, 128, 128, 2'b00));
		// touching faces on x, depth zero
		send_pair(mk(z0, u1, xyz(256, 0, 0), xyz(512, 256, 256), xyz(256, 0, 0),
			xyz(-256, 0, 0), 256, 256, 256, 256, 2'b00));
		// identical boxes: three-way tie resolves to x
		send_pair(mk(z0, u1, z0, u1, xyz(100, 0, 0), xyz(-100, 0, 0),
			256, 256, 200, 100, 2'b00));
		// y and z tie, smaller than x
		send_pair(mk(z0, xyz(1024, 256, 256), xyz(0, 128, 128), xyz(1024, 512, 512),
			xyz(0, 50, 50), xyz(0, -50, -50), 256, 512, 64, 192, 2'b00));
		// z alone least
		send_pair(mk(z0, xyz(1024, 1024, 256), xyz(0, 0, 200), xyz(1024, 1024, 600),
			xyz(0, 0, 300), xyz(0, 0, -300), 100, 300, 256, 256, 2'b00));
		// A centre above B: positive normal, approaching
		send_pair(mk(xyz(200, 0, 0), xyz(456, 1024, 1024), z0, xyz(256, 1024, 1024),
			xyz(-512, 0, 0), xyz(512, 0, 0), 256, 256, 128, 256, 2'b00));
		// same geometry, separating: shifts only
		send_pair(mk(xyz(200, 0, 0), xyz(456, 1024, 1024), z0, xyz(256, 1024, 1024),
			xyz(512, 0, 0), xyz(-512, 0, 0), 256, 256, 128, 256, 2'b00));
		// each static flag, then both
		send_pair(mk(z0, u1, xyz(128, 0, 0), xyz(384, 256, 256), xyz(300, 0, 0),
			xyz(-300, 0, 0), 256, 256, 256, 256, STATIC_A));
		send_pair(mk(z0, u1, xyz(128, 0, 0), xyz(384, 256, 256), xyz(300, 0, 0),
			xyz(-300, 0, 0), 256, 256, 256, 256, STATIC_B));
		send_pair(mk(z0, u1, xyz(128, 0, 0), xyz(384, 256, 256), xyz(300, 0, 0),
			xyz(-300, 0, 0), 256, 256, 256, 256, STATIC_A | STATIC_B));
		// zero inverse mass sum
		send_pair(mk(z0, u1, xyz(128, 0, 0), xyz(384, 256, 256), xyz(300, 0, 0),
			xyz(-300, 0, 0), 0, 0, 256, 256, 2'b00));
		// one infinite-mass body
		send_pair(mk(z0, u1, xyz(128, 0, 0), xyz(384, 256, 256), xyz(300, 0, 0),
			xyz(-300, 0, 0), 0, 65535, 256, 256, 2'b00));
		// restitution above one, both at 511
		send_pair(mk(z0, u1, xyz(128, 0, 0), xyz(384, 256, 256), xyz(300, 0, 0),
			xyz(-300, 0, 0), 256, 256, 511, 511, 2'b00));
		// inverted A box
		send_pair(mk(u1, z0, xyz(64, 64, 64), xyz(192, 192, 192), xyz(10, 20, 30),
			xyz(-10, -20, -30), 256, 256, 0, 0, 2'b00));
		// full-range boxes: depth at the 16-bit maximum
		send_pair(mk(xyz(-32768, -32768, -32768), xyz(32767, 32767, 32767),
			xyz(-32768, -32768, -32768), xyz(32767, 32767, 32767),
			xyz(32767, 32767, 32767), xyz(-32768, -32768, -32768),
			65535, 65535, 256, 256, 2'b00));
		// extreme velocities, heavy imbalance: velocity saturation
		send_pair(mk(xyz(-32768, -32768, -32768), xyz(100, 32767, 32767),
			xyz(0, -32768, -32768), xyz(32767, 32767, 32767),
			xyz(32767, 0, 0), xyz(-32768, 0, 0), 65535, 1, 256, 256, 2'b00));
		// all-ones and all-zero words
		send_pair(mk('1, '1, '1, '1, '1, '1, 65535, 65535, 511, 511, 2'b11));
		send_pair(mk('0, '0, '0, '0, '0, '0, 0, 0, 0, 0, 2'b00));
		// odd mass split to exercise rounding ties
		send_pair(mk(z0, xyz(3, 256, 256), xyz(0, 0, 0), xyz(3, 512, 512),
			xyz(1, 0, 0), xyz(0, 0, 0), 1, 1, 0, 0, 2'b00));
		send_pair(mk(z0, xyz(5, 256, 256), xyz(2, 0, 0), xyz(300, 512, 512),
			xyz(3, 0, 0), xyz(-2, 0, 0), 1, 3, 128, 0, 2'b00));
	endtask

	task automatic test_random(int count);
		repeat (count) send_pair(rand_pair());
	endtask

	// long output hold-off while pairs keep coming: the unit must fill and stall
	task automatic test_backpressure();
		hold_count++;
		idle_on = 1'b0;
		repeat (60) send_pair(rand_pair());
		idle_on = 1'b1;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (contact_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(180);
		test_backpressure();
		idle_on = 1'b0;
		test_random(80);        // streaming, no gaps or stalls
		idle_on = 1'b1;
		test_random(80);
		drain();
		$display("%0d pairs sent, %0d results scored: %0d contacts, %0d mass faults",
			n_sent, n_checked, n_hits, n_faults);
		$display("directed corners, random pairs with gaps, streaming and a long hold-off");
		if (n_errors == 0 && contact_q.size() == 0 && n_checked == n_sent)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

[files.f]
+incdir+src
src/aci_pkg.sv
src/aci_div.sv
src/aci_front.sv
src/aci_queue.sv
src/aci_back.sv
src/aabb_contact_impulse_unit.sv
src/aci_checker.sv
sim/aabb_contact_impulse_unit_tb.sv
